### hdl/pmp_pkg.sv
// Package for the piece model parser: item types, phase codes, result kinds.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package pmp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  text_byte;
    logic [31:0] score_bits;
    logic [31:0] piece_index;
    logic [1:0]  final_status;
    logic [31:0] model_kind;
    logic        run_last;
  } out_item_t;

  // Up to three result items caused by one input item.
  typedef struct packed {
    out_item_t [2:0] r;
    logic [1:0]      n;
  } batch_t;

  localparam logic [1:0] EV_TEXT_START = 2'd0;
  localparam logic [1:0] EV_TEXT_BYTE  = 2'd1;
  localparam logic [1:0] EV_PIECE_DONE = 2'd2;
  localparam logic [1:0] EV_FINAL      = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_NO_PIECES = 2'd2;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd3;

  localparam logic [1:0] VF_MORE = 2'd0;
  localparam logic [1:0] VF_DONE = 2'd1;
  localparam logic [1:0] VF_FAIL = 2'd2;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  typedef enum logic [8:0] {
    PH_TAG    = 9'b000000001,
    PH_PLEN   = 9'b000000010,
    PH_SLEN   = 9'b000000100,
    PH_KLEN   = 9'b000001000,
    PH_KVAR   = 9'b000010000,
    PH_KBYTES = 9'b000100000,
    PH_PIECE  = 9'b001000000,
    PH_SPEC   = 9'b010000000,
    PH_STOP   = 9'b100000000
  } phase_t;

  typedef enum logic [7:0] {
    IN_TAG    = 8'b00000001,
    IN_TLEN   = 8'b00000010,
    IN_TEXT   = 8'b00000100,
    IN_SCORE  = 8'b00001000,
    IN_TYPE   = 8'b00010000,
    IN_KVAR   = 8'b00100000,
    IN_KLEN   = 8'b01000000,
    IN_KBYTES = 8'b10000000
  } inner_t;

  typedef struct packed {
    logic [63:0] accum;
    logic [3:0]  shift;
    logic [1:0]  status;
  } vfeed_t;

  function automatic vfeed_t vfeed(input logic [63:0] accum, input logic [3:0] shift,
                                   input logic [7:0] b);
    vfeed_t     f;
    logic [5:0] sh;
    sh = 6'(7 * shift);
    f.accum = accum | (64'(b[6:0]) << sh);
    f.shift = shift;
    if (!b[7]) begin
      f.status = VF_DONE;
    end else begin
      f.shift = shift + 4'd1;
      f.status = (f.shift >= 4'd10) ? VF_FAIL : VF_MORE;
    end
    return f;
  endfunction

  function automatic out_item_t mk(input logic [1:0] kind, input logic [7:0] tb,
                                   input logic [31:0] sc, input logic [31:0] idx,
                                   input logic [1:0] st, input logic [31:0] mkind);
    out_item_t o;
    o.event_kind = kind;
    o.text_byte = tb;
    o.score_bits = sc;
    o.piece_index = idx;
    o.final_status = st;
    o.model_kind = mkind;
    o.run_last = 1'b0;
    return o;
  endfunction

endpackage

### hdl/pmp_core.sv
// Parser state and per-byte next-state logic; yields the batch of results.
// Depends on pmp_pkg.
`timescale 1ns / 1ps
module pmp_core #(
  parameter int LEN_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  pmp_pkg::in_item_t item,
  output pmp_pkg::batch_t   batch
);
  import pmp_pkg::*;

  phase_t              parse_phase, parse_phase_next;
  logic [63:0]         varint_accum, varint_accum_next;
  logic [3:0]          varint_shift, varint_shift_next;
  logic [LEN_BITS-1:0] outer_left, outer_left_next;
  inner_t              inner_phase, inner_phase_next;
  logic                inner_failed, inner_failed_next;
  logic [LEN_BITS-1:0] inner_left, inner_left_next;
  logic [LEN_BITS-1:0] field_left, field_left_next;
  logic [31:0]         score_reg, score_reg_next;
  logic [1:0]          score_byte_pos, score_byte_pos_next;
  logic [31:0]         pending_type, pending_type_next;
  logic [31:0]         model_type_reg, model_type_reg_next;
  logic [31:0]         piece_count, piece_count_next;
  logic                stopped, stopped_next;
  logic                corrupt_flag, corrupt_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_TAG;
      varint_accum <= '0;
      varint_shift <= '0;
      outer_left <= '0;
      inner_phase <= IN_TAG;
      inner_failed <= 1'b0;
      inner_left <= '0;
      field_left <= '0;
      score_reg <= '0;
      score_byte_pos <= '0;
      pending_type <= 32'd1;
      model_type_reg <= 32'd1;
      piece_count <= '0;
      stopped <= 1'b0;
      corrupt_flag <= 1'b0;
    end else if (fire) begin
      parse_phase <= parse_phase_next;
      varint_accum <= varint_accum_next;
      varint_shift <= varint_shift_next;
      outer_left <= outer_left_next;
      inner_phase <= inner_phase_next;
      inner_failed <= inner_failed_next;
      inner_left <= inner_left_next;
      field_left <= field_left_next;
      score_reg <= score_reg_next;
      score_byte_pos <= score_byte_pos_next;
      pending_type <= pending_type_next;
      model_type_reg <= model_type_reg_next;
      piece_count <= piece_count_next;
      stopped <= stopped_next;
      corrupt_flag <= corrupt_flag_next;
    end
  end

  always_comb begin
    vfeed_t              vf;
    logic [63:0]         v;
    logic                piece;
    logic [LEN_BITS-1:0] ol;
    logic [1:0]          n;
    logic [1:0]          st;
    logic [4:0]          bsh;
    out_item_t [2:0]     res;

    parse_phase_next = parse_phase;
    varint_accum_next = varint_accum;
    varint_shift_next = varint_shift;
    outer_left_next = outer_left;
    inner_phase_next = inner_phase;
    inner_failed_next = inner_failed;
    inner_left_next = inner_left;
    field_left_next = field_left;
    score_reg_next = score_reg;
    score_byte_pos_next = score_byte_pos;
    pending_type_next = pending_type;
    model_type_reg_next = model_type_reg;
    piece_count_next = piece_count;
    stopped_next = stopped;
    corrupt_flag_next = corrupt_flag;
    res = '0;
    n = 2'd0;
    st = ST_OK;
    vf = vfeed(varint_accum, varint_shift, item.in_byte);
    v = vf.accum;
    piece = (parse_phase == PH_PIECE);
    ol = (outer_left != '0) ? outer_left - 1'b1 : outer_left;
    bsh = {score_byte_pos, 3'b000};

    if (!stopped) begin
      unique case (parse_phase)
        PH_TAG: begin
          if (vf.status == VF_MORE) begin
            varint_accum_next = vf.accum;
            varint_shift_next = vf.shift;
          end else begin
            varint_accum_next = '0;
            varint_shift_next = '0;
            if (vf.status == VF_FAIL) begin
              stopped_next = 1'b1;
              parse_phase_next = PH_STOP;
            end else if (v[63:3] == 61'd1 && v[2:0] == WT_LEN) begin
              parse_phase_next = PH_PLEN;
            end else if (v[63:3] == 61'd2 && v[2:0] == WT_LEN) begin
              parse_phase_next = PH_SLEN;
            end else if (v[2:0] == WT_VARINT) begin
              parse_phase_next = PH_KVAR;
            end else if (v[2:0] == WT_LEN) begin
              parse_phase_next = PH_KLEN;
            end else if (v[2:0] == WT_FIX64) begin
              outer_left_next = LEN_BITS'(8);
              parse_phase_next = PH_KBYTES;
            end else if (v[2:0] == WT_FIX32) begin
              outer_left_next = LEN_BITS'(4);
              parse_phase_next = PH_KBYTES;
            end else begin
              stopped_next = 1'b1;
              parse_phase_next = PH_STOP;
            end
          end
        end
        PH_PLEN, PH_SLEN, PH_KLEN: begin
          if (vf.status == VF_MORE) begin
            varint_accum_next = vf.accum;
            varint_shift_next = vf.shift;
          end else begin
            varint_accum_next = '0;
            varint_shift_next = '0;
            if (vf.status == VF_FAIL || (v >> LEN_BITS) != 64'd0) begin
              stopped_next = 1'b1;
              parse_phase_next = PH_STOP;
              if (parse_phase == PH_PLEN) corrupt_flag_next = 1'b1;
            end else if (v == 64'd0) begin
              if (parse_phase == PH_PLEN) begin
                piece_count_next = piece_count + 32'd1;
                res[n] = mk(EV_PIECE_DONE, 8'd0, 32'd0, piece_count_next, ST_OK, 32'd0);
                n = n + 2'd1;
              end
              parse_phase_next = PH_TAG;
            end else begin
              outer_left_next = v[LEN_BITS-1:0];
              inner_phase_next = IN_TAG;
              inner_failed_next = 1'b0;
              inner_left_next = '0;
              field_left_next = '0;
              score_byte_pos_next = '0;
              if (parse_phase == PH_PLEN) begin
                score_reg_next = '0;
                parse_phase_next = PH_PIECE;
              end else if (parse_phase == PH_SLEN) begin
                pending_type_next = model_type_reg;
                parse_phase_next = PH_SPEC;
              end else begin
                parse_phase_next = PH_KBYTES;
              end
            end
          end
        end
        PH_KVAR: begin
          if (vf.status == VF_MORE) begin
            varint_accum_next = vf.accum;
            varint_shift_next = vf.shift;
          end else begin
            varint_accum_next = '0;
            varint_shift_next = '0;
            if (vf.status == VF_FAIL) begin
              stopped_next = 1'b1;
              parse_phase_next = PH_STOP;
            end else begin
              parse_phase_next = PH_TAG;
            end
          end
        end
        PH_KBYTES: begin
          outer_left_next = ol;
          if (ol == '0) parse_phase_next = PH_TAG;
        end
        PH_PIECE, PH_SPEC: begin
          outer_left_next = ol;
          // Inner field decode of one submessage byte.
          if (!inner_failed) begin
            unique case (inner_phase)
              IN_TAG: begin
                if (vf.status == VF_MORE) begin
                  varint_accum_next = vf.accum;
                  varint_shift_next = vf.shift;
                end else begin
                  varint_accum_next = '0;
                  varint_shift_next = '0;
                  if (vf.status == VF_FAIL) begin
                    inner_failed_next = 1'b1;
                  end else if (piece && v[63:3] == 61'd1 && v[2:0] == WT_LEN) begin
                    inner_phase_next = IN_TLEN;
                  end else if (piece && v[63:3] == 61'd2 && v[2:0] == WT_FIX32) begin
                    if (ol < LEN_BITS'(4)) begin
                      inner_failed_next = 1'b1;
                    end else begin
                      score_byte_pos_next = '0;
                      inner_phase_next = IN_SCORE;
                    end
                  end else if (!piece && v[63:3] == 61'd3 && v[2:0] == WT_VARINT) begin
                    inner_phase_next = IN_TYPE;
                  end else if (v[2:0] == WT_VARINT) begin
                    inner_phase_next = IN_KVAR;
                  end else if (v[2:0] == WT_LEN) begin
                    inner_phase_next = IN_KLEN;
                  end else if (v[2:0] == WT_FIX64 || v[2:0] == WT_FIX32) begin
                    if (ol < ((v[2:0] == WT_FIX64) ? LEN_BITS'(8) : LEN_BITS'(4))) begin
                      inner_failed_next = 1'b1;
                    end else begin
                      inner_left_next = (v[2:0] == WT_FIX64) ? LEN_BITS'(8) : LEN_BITS'(4);
                      inner_phase_next = IN_KBYTES;
                    end
                  end else begin
                    inner_failed_next = 1'b1;
                  end
                end
              end
              IN_TLEN, IN_KLEN: begin
                if (vf.status == VF_MORE) begin
                  varint_accum_next = vf.accum;
                  varint_shift_next = vf.shift;
                end else begin
                  varint_accum_next = '0;
                  varint_shift_next = '0;
                  if (vf.status == VF_FAIL || v > 64'(ol)) begin
                    inner_failed_next = 1'b1;
                  end else if (inner_phase == IN_TLEN) begin
                    res[n] = mk(EV_TEXT_START, 8'd0, 32'd0, 32'd0, ST_OK, 32'd0);
                    n = n + 2'd1;
                    field_left_next = v[LEN_BITS-1:0];
                    inner_phase_next = (v == 64'd0) ? IN_TAG : IN_TEXT;
                  end else begin
                    inner_left_next = v[LEN_BITS-1:0];
                    inner_phase_next = (v == 64'd0) ? IN_TAG : IN_KBYTES;
                  end
                end
              end
              IN_TEXT: begin
                res[n] = mk(EV_TEXT_BYTE, item.in_byte, 32'd0, 32'd0, ST_OK, 32'd0);
                n = n + 2'd1;
                field_left_next = field_left - 1'b1;
                if (field_left_next == '0) inner_phase_next = IN_TAG;
              end
              IN_SCORE: begin
                score_reg_next = (score_reg & ~(32'hFF << bsh)) | (32'(item.in_byte) << bsh);
                score_byte_pos_next = score_byte_pos + 2'd1;
                if (score_byte_pos == 2'd3) inner_phase_next = IN_TAG;
              end
              IN_TYPE: begin
                if (vf.status == VF_MORE) begin
                  varint_accum_next = vf.accum;
                  varint_shift_next = vf.shift;
                end else begin
                  varint_accum_next = '0;
                  varint_shift_next = '0;
                  if (vf.status == VF_FAIL) begin
                    pending_type_next = 32'd0;
                    inner_failed_next = 1'b1;
                  end else begin
                    pending_type_next = v[31:0];
                    inner_phase_next = IN_TAG;
                  end
                end
              end
              IN_KVAR: begin
                if (vf.status == VF_MORE) begin
                  varint_accum_next = vf.accum;
                  varint_shift_next = vf.shift;
                end else begin
                  varint_accum_next = '0;
                  varint_shift_next = '0;
                  if (vf.status == VF_FAIL) inner_failed_next = 1'b1;
                  else inner_phase_next = IN_TAG;
                end
              end
              IN_KBYTES: begin
                inner_left_next = (inner_left != '0) ? inner_left - 1'b1 : inner_left;
                if (inner_left_next == '0) inner_phase_next = IN_TAG;
              end
              default: ;
            endcase
          end
          // Submessage complete: report the piece or commit the model type.
          if (ol == '0) begin
            if (piece) begin
              piece_count_next = piece_count + 32'd1;
              res[n] = mk(EV_PIECE_DONE, 8'd0, score_reg_next, piece_count_next, ST_OK,
                          32'd0);
              n = n + 2'd1;
            end else begin
              if (!inner_failed_next && inner_phase_next == IN_TYPE) pending_type_next = 32'd0;
              model_type_reg_next = pending_type_next;
            end
            varint_accum_next = '0;
            varint_shift_next = '0;
            inner_phase_next = IN_TAG;
            inner_failed_next = 1'b0;
            inner_left_next = '0;
            field_left_next = '0;
            score_byte_pos_next = '0;
            parse_phase_next = PH_TAG;
          end
        end
        default: begin
          stopped_next = 1'b1;
          parse_phase_next = PH_STOP;
        end
      endcase
    end

    if (item.in_last) begin
      if (corrupt_flag_next || parse_phase_next == PH_PLEN || parse_phase_next == PH_PIECE)
        st = ST_TRUNCATED;
      else if (piece_count_next == 32'd0) st = ST_NO_PIECES;
      else if (model_type_reg_next == 32'd2 || model_type_reg_next == 32'd3) st = ST_BAD_TYPE;
      else st = ST_OK;
      res[n] = mk(EV_FINAL, 8'd0, 32'd0, piece_count_next, st, model_type_reg_next);
      n = n + 2'd1;
      parse_phase_next = PH_TAG;
      varint_accum_next = '0;
      varint_shift_next = '0;
      outer_left_next = '0;
      inner_phase_next = IN_TAG;
      inner_failed_next = 1'b0;
      inner_left_next = '0;
      field_left_next = '0;
      score_byte_pos_next = '0;
      score_reg_next = '0;
      pending_type_next = 32'd1;
      model_type_reg_next = 32'd1;
      piece_count_next = '0;
      stopped_next = 1'b0;
      corrupt_flag_next = 1'b0;
    end

    if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;
    batch.r = res;
    batch.n = n;
  end

endmodule

### hdl/pmp_result_buf.sv
// Result register: holds the batch of one byte and hands items out in order.
// Depends on pmp_pkg.
`timescale 1ns / 1ps
module pmp_result_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pmp_pkg::batch_t    batch,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output pmp_pkg::out_item_t out_data
);
  import pmp_pkg::*;

  out_item_t [2:0] held;
  logic [1:0]      count;
  logic [1:0]      rd;
  logic            take;

  assign out_valid = (count != 2'd0);
  assign take = out_valid && !out_stall;
  assign can_load = (count == 2'd0) || (count == 2'd1 && take);
  assign out_data = held[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd <= '0;
    end else if (load) begin
      count <= batch.n;
      rd <= '0;
    end else if (take) begin
      count <= count - 2'd1;
      rd <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= batch.r;
  end

endmodule

### hdl/protobuf_piece_model_parser_unit.sv
// Top level of the piece model parser: byte channel in, event channel out.
// Depends on pmp_pkg, pmp_core and pmp_result_buf.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     pmp_pkg::in_item_t  (in_byte, in_last)
//   out      output     out_valid / out_stall   pmp_pkg::out_item_t (event fields)
//
// One byte is parsed in the cycle it is accepted; its zero to three result items
// sit in the result register and leave one per cycle from the next cycle on while
// out_stall is low. A byte that causes at most one result lets the next byte in
// at once unless the output stalls; a byte with two or three results holds the
// input until its last item leaves. Reset (rst, synchronous) returns the parser to
// the outer tag phase and empties the result register. An output stall holds the
// current item and, once the register cannot drain, stalls the input.
`timescale 1ns / 1ps
module protobuf_piece_model_parser_unit #(
  parameter int LEN_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pmp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pmp_pkg::out_item_t out_data
);
  import pmp_pkg::*;

  batch_t batch;
  logic   can_load;
  logic   fire;

  // Advance the parser only on an accepted byte.
  assign in_stall = !can_load;
  assign fire = in_valid && can_load;

  pmp_core #(
    .LEN_BITS(LEN_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_data),
    .batch(batch)
  );

  pmp_result_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .batch    (batch),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
